// File: rtl/mpbd_pkg.sv
// Package for the multi-press button detector.
// Holds the item and configuration types, register indexes and reset values.
// Used by every module under rtl/.
`default_nettype none

package mpbd_pkg;

    localparam int unsigned TimerW = 16;
    localparam int unsigned CountW = 4;
    localparam int unsigned BlinkW = 3;

    localparam logic [TimerW-1:0] DebounceReset = 16'd20;
    localparam logic [TimerW-1:0] GapReset      = 16'd500;
    localparam logic [TimerW-1:0] BlinkOnReset  = 16'd400;
    localparam logic [TimerW-1:0] BlinkOffReset = 16'd200;

    localparam logic [CountW-1:0] CountMax = 4'd15;

    typedef enum logic [1:0] {
        CFG_DEBOUNCE  = 2'd0,
        CFG_GAP       = 2'd1,
        CFG_BLINK_ON  = 2'd2,
        CFG_BLINK_OFF = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [TimerW-1:0] debounce_ticks;
        logic [TimerW-1:0] gap_ticks;
        logic [TimerW-1:0] blink_on_ticks;
        logic [TimerW-1:0] blink_off_ticks;
    } t_cfg;

    typedef struct packed {
        logic press_edge;
        logic button_level;
    } t_in_item;

    typedef struct packed {
        logic              gesture_done;
        logic [CountW-1:0] press_count;
        logic              green_led;
    } t_out_item;

endpackage

`default_nettype wire

// File: rtl/mpbd_cfg_regs.sv
// Configuration registers of the multi-press button detector.
// Plain write port, reset to the package defaults; depends on mpbd_pkg.
`default_nettype none

module mpbd_cfg_regs (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [1:0]              i_cfg_idx,
    input  wire logic [15:0]             i_cfg_data,
    output mpbd_pkg::t_cfg               o_cfg
);
    import mpbd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_DEBOUNCE:  n_cfg.debounce_ticks  = i_cfg_data;
                CFG_GAP:       n_cfg.gap_ticks       = i_cfg_data;
                CFG_BLINK_ON:  n_cfg.blink_on_ticks  = i_cfg_data;
                CFG_BLINK_OFF: n_cfg.blink_off_ticks = i_cfg_data;
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks  <= DebounceReset;
            r_cfg.gap_ticks       <= GapReset;
            r_cfg.blink_on_ticks  <= BlinkOnReset;
            r_cfg.blink_off_ticks <= BlinkOffReset;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: rtl/mpbd_tracker.sv
// Press, debounce, gap and blinker state of the multi-press button detector.
// Advances one tick per step and forms that tick's result; depends on mpbd_pkg.
`default_nettype none

module mpbd_tracker (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_step,
    input  wire mpbd_pkg::t_in_item      i_item,
    input  wire mpbd_pkg::t_cfg          i_cfg,
    output mpbd_pkg::t_out_item          o_result
);
    import mpbd_pkg::*;

    logic              r_press, n_press;
    logic [CountW-1:0] r_count, n_count;
    logic [TimerW-1:0] r_deb_left, n_deb_left;
    logic              r_deb_run, n_deb_run;
    logic [TimerW-1:0] r_gap_left, n_gap_left;
    logic              r_gap_run, n_gap_run;
    logic [TimerW-1:0] r_blk_left, n_blk_left;
    logic              r_blk_run, n_blk_run;
    logic [BlinkW-1:0] r_blk_rem, n_blk_rem;
    logic              r_led, n_led;

    logic              blk_exp, deb_exp, gap_exp;
    logic [TimerW-1:0] blk_next;
    logic [CountW-1:0] reported;

    always_comb begin
        n_press    = r_press;
        n_count    = r_count;
        n_deb_left = r_deb_left;
        n_deb_run  = r_deb_run;
        n_gap_left = r_gap_left;
        n_gap_run  = r_gap_run;
        n_blk_left = r_blk_left;
        n_blk_run  = r_blk_run;
        n_blk_rem  = r_blk_rem;
        n_led      = r_led;
        blk_exp    = 1'b0;
        deb_exp    = 1'b0;
        gap_exp    = 1'b0;
        blk_next   = i_cfg.blink_on_ticks;
        reported   = '0;

        if (r_blk_run) begin
            if (r_blk_left <= 16'd1) begin
                n_blk_left = '0;
                n_blk_run  = 1'b0;
                blk_exp    = 1'b1;
            end else begin
                n_blk_left = r_blk_left - 16'd1;
            end
        end
        if (blk_exp) begin
            if (r_led) begin
                if (r_blk_rem != '0) begin
                    n_blk_rem = r_blk_rem - 3'd1;
                end
                n_led    = 1'b0;
                blk_next = i_cfg.blink_off_ticks;
            end else begin
                n_led    = 1'b1;
                blk_next = i_cfg.blink_on_ticks;
            end
            if (n_blk_rem != '0) begin
                n_blk_left = blk_next;
                n_blk_run  = 1'b1;
            end
        end

        if (r_deb_run) begin
            if (r_deb_left <= 16'd1) begin
                n_deb_left = '0;
                n_deb_run  = 1'b0;
                deb_exp    = 1'b1;
            end else begin
                n_deb_left = r_deb_left - 16'd1;
            end
        end
        if (deb_exp) begin
            if (i_item.button_level) begin
                n_deb_left = i_cfg.debounce_ticks;
                n_deb_run  = 1'b1;
            end else begin
                n_gap_left = i_cfg.gap_ticks;
                n_gap_run  = 1'b1;
                n_press    = 1'b0;
            end
        end

        if (n_gap_run) begin
            if (n_gap_left <= 16'd1) begin
                n_gap_left = '0;
                n_gap_run  = 1'b0;
                gap_exp    = 1'b1;
            end else begin
                n_gap_left = n_gap_left - 16'd1;
            end
        end
        if (gap_exp) begin
            reported = r_count;
            if (reported inside {4'd1, 4'd2, 4'd4, 4'd5}) begin
                n_led      = 1'b1;
                n_blk_rem  = reported[BlinkW-1:0];
                n_blk_left = i_cfg.blink_on_ticks;
                n_blk_run  = 1'b1;
            end
            n_count = '0;
        end

        if (i_item.press_edge && !n_press) begin
            n_press = 1'b1;
            if (n_count < CountMax) begin
                n_count = n_count + 4'd1;
            end
            n_deb_left = i_cfg.debounce_ticks;
            n_deb_run  = 1'b1;
            n_gap_left = i_cfg.gap_ticks;
            n_gap_run  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press    <= 1'b0;
            r_count    <= '0;
            r_deb_left <= '0;
            r_deb_run  <= 1'b0;
            r_gap_left <= '0;
            r_gap_run  <= 1'b0;
            r_blk_left <= '0;
            r_blk_run  <= 1'b0;
            r_blk_rem  <= '0;
            r_led      <= 1'b0;
        end else if (i_step) begin
            r_press    <= n_press;
            r_count    <= n_count;
            r_deb_left <= n_deb_left;
            r_deb_run  <= n_deb_run;
            r_gap_left <= n_gap_left;
            r_gap_run  <= n_gap_run;
            r_blk_left <= n_blk_left;
            r_blk_run  <= n_blk_run;
            r_blk_rem  <= n_blk_rem;
            r_led      <= n_led;
        end
    end

    assign o_result.gesture_done = gap_exp;
    assign o_result.press_count  = reported;
    assign o_result.green_led    = n_led;

`ifndef SYNTHESIS
    a_press_has_debounce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_press |-> r_deb_run)
        else $error("press active without debounce timer");
    a_count_has_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> r_gap_run)
        else $error("pending presses without gap timer");
    a_blink_has_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blk_run |-> (r_blk_rem != '0))
        else $error("blinker running with no blinks left");
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_count) && $stable(r_led) && $stable(r_gap_left))
        else $error("state moved without a step");
`endif

endmodule

`default_nettype wire

// File: rtl/multi_press_button_detector.sv
// Multi-press button detector: top level.
// Input register, tick tracker and result register; depends on mpbd_pkg,
// mpbd_cfg_regs and mpbd_tracker.
//   Input channel (i_in_valid / o_in_ready / i_in_item) carries one time tick
//   per item: press edge flag and sampled button level.
//   Output channel (o_out_valid / i_out_ready / o_out_item) returns exactly one
//   item per tick: gesture done flag, press count, green LED drive.
//   Configuration port (i_cfg_we / i_cfg_idx / i_cfg_data) writes debounce,
//   gap, blink-on and blink-off tick counts; write only while idle.
// Timing:
//   An item is registered on acceptance; its result is registered in the
//   output register when the tracker advances, which waits while a result is held.
//   Throughput is one item per cycle while results are taken, set by the
//   combinational tracker update between the input and result registers.
// Reset:
//   Synchronous, active low; clears all press, timer and blinker state,
//   empties both registers and restores the default tick counts.
// Stall:
//   While a result waits, the tracker and input register hold; o_in_ready
//   drops once the input register is also full.
`default_nettype none

module multi_press_button_detector (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire mpbd_pkg::t_in_item      i_in_item,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output mpbd_pkg::t_out_item          o_out_item,
    input  wire logic                    i_cfg_we,
    input  wire logic [1:0]              i_cfg_idx,
    input  wire logic [15:0]             i_cfg_data
);
    import mpbd_pkg::*;

    t_cfg      cfg;
    t_out_item result;
    logic      advance;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    mpbd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    mpbd_tracker u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire
